FILE: hw/rtl/rtp_header_extension_parser_top_assert.svh
// ----------------------------------------------------------------------------
// RTP header extension parser - assertion macros
// Shared forms for the concurrent checks of the parser blocks.
// ----------------------------------------------------------------------------
`ifndef RTP_HEADER_EXTENSION_PARSER_TOP_ASSERT_SVH
`define RTP_HEADER_EXTENSION_PARSER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define RHEP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define RHEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rhep_pkg.sv
// ----------------------------------------------------------------------------
// rhep_pkg
// Types and constants shared by the RTP header extension parser.
// ----------------------------------------------------------------------------
package rhep_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 65536;
    localparam int SUM_W                = 20;

    localparam logic [15:0] PROFILE_ONE_BYTE = 16'hBEDE;
    localparam logic [15:0] PROFILE_TWO_BYTE = 16'h1000;
    localparam logic [3:0]  LOW_NIBBLE_MASK  = 4'hF;
    localparam logic [7:0]  FIXED_HDR_BYTES  = 8'd12;

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [7:0] {
        PH_FIXED   = 8'b0000_0001,
        PH_CSRC    = 8'b0000_0010,
        PH_EXTHDR  = 8'b0000_0100,
        PH_WALK    = 8'b0000_1000,
        PH_LEN2    = 8'b0001_0000,
        PH_VALUE   = 8'b0010_0000,
        PH_SKIP    = 8'b0100_0000,
        PH_PAYLOAD = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ext_id;
        logic [7:0]  ext_length;
        logic [15:0] ext_offset;
        logic [15:0] seq_number;
        logic [31:0] timestamp;
        logic [31:0] ssrc;
        logic [6:0]  payload_type;
        logic        marker;
        logic [15:0] payload_offset;
        logic [15:0] payload_size;
        logic        error;
    } t_result;

endpackage

FILE: hw/rtl/rtp_header_extension_parser_top.sv
// ----------------------------------------------------------------------------
// rtp_header_extension_parser_top
// RTP fixed header and header extension parser, one packet byte per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | sink      | i_valid / o_stall  | i_data_byte, i_last_byte
//  out     | source    | o_valid / i_stall  | o_kind .. o_error (element/summary)
//  cfg     | sink      | i_cfg_we           | i_cfg_data (prefix length)
//
//  One byte per cycle sustained unless the result stalls; a byte's result goes
//  from the input register through the parse logic into the result register.
//  Synchronous active-low reset clears the pipeline and all packet state.
//  A stalled result holds the result register; one more byte waits in the
//  input register, after which o_stall rises.
// ----------------------------------------------------------------------------
`include "rtp_header_extension_parser_top_assert.svh"

module rtp_header_extension_parser_top #(
    parameter int MAX_PACKET_BYTES = rhep_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_ext_id,
    output logic [7:0]  o_ext_length,
    output logic [15:0] o_ext_offset,
    output logic [15:0] o_seq_number,
    output logic [31:0] o_timestamp,
    output logic [31:0] o_ssrc,
    output logic [6:0]  o_payload_type,
    output logic        o_marker,
    output logic [15:0] o_payload_offset,
    output logic [15:0] o_payload_size,
    output logic        o_error
);

    logic              advance;
    logic              fire;
    logic              in_vld;
    logic [7:0]        in_byte;
    logic              in_last;
    logic              has_res;
    rhep_pkg::t_result res;
    rhep_pkg::t_result out_res;

    assign advance = !o_valid || !i_stall;
    assign fire    = in_vld && advance;

    rhep_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_advance   (advance),
        .o_vld       (in_vld),
        .o_data_byte (in_byte),
        .o_last_byte (in_last)
    );

    rhep_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_byte     (in_byte),
        .i_last     (in_last),
        .o_has_res  (has_res),
        .o_res      (res)
    );

    rhep_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_load    (fire && has_res),
        .i_res     (res),
        .o_valid   (o_valid),
        .o_res     (out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_ext_id         = out_res.ext_id;
    assign o_ext_length     = out_res.ext_length;
    assign o_ext_offset     = out_res.ext_offset;
    assign o_seq_number     = out_res.seq_number;
    assign o_timestamp      = out_res.timestamp;
    assign o_ssrc           = out_res.ssrc;
    assign o_payload_type   = out_res.payload_type;
    assign o_marker         = out_res.marker;
    assign o_payload_offset = out_res.payload_offset;
    assign o_payload_size   = out_res.payload_size;
    assign o_error          = out_res.error;

    `RHEP_ASSERT_NOW(a_summary_no_ext, i_clk, i_rst_n, o_valid && o_kind == rhep_pkg::KIND_SUMMARY, o_ext_id == 8'd0 && o_ext_length == 8'd0 && o_ext_offset == 16'd0, "summary item carries element fields")
    `RHEP_ASSERT_NOW(a_element_no_sum, i_clk, i_rst_n, o_valid && o_kind == rhep_pkg::KIND_ELEMENT, !o_error && o_payload_size == 16'd0 && o_ssrc == 32'd0, "element item carries summary fields")
    `RHEP_ASSERT_NOW(a_error_size, i_clk, i_rst_n, o_valid && o_error, o_payload_size == 16'd0, "error summary with nonzero payload size")

endmodule

FILE: hw/rtl/rhep_in_stage.sv
// ----------------------------------------------------------------------------
// rhep_in_stage
// Input register: holds one packet byte until the parser takes it.
// ----------------------------------------------------------------------------
module rhep_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_advance,
    output logic       o_vld,
    output logic [7:0] o_data_byte,
    output logic       o_last_byte
);

    logic       r_vld;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;

    assign o_stall = r_vld && !i_advance;
    assign load    = !r_vld || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    assign o_vld       = r_vld;
    assign o_data_byte = r_byte;
    assign o_last_byte = r_last;

endmodule

FILE: hw/rtl/rhep_parser.sv
// ----------------------------------------------------------------------------
// rhep_parser
// Per-packet parse state and the one-pass logic for each byte.
// ----------------------------------------------------------------------------
`include "rtp_header_extension_parser_top_assert.svh"

module rhep_parser #(
    parameter int MAX_PACKET_BYTES = rhep_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_data,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_has_res,
    output rhep_pkg::t_result o_res
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int SW    = rhep_pkg::SUM_W;

    logic [2:0]       r_prefix;
    logic [POS_W-1:0] r_pos,  n_pos;
    rhep_pkg::t_phase r_phase, n_phase;
    logic [63:0]      r_hdr0, n_hdr0;
    logic [47:0]      r_hdr1, n_hdr1;
    logic             r_pad_f, n_pad_f;
    logic             r_ext_f, n_ext_f;
    logic             r_ovf,  n_ovf;
    logic [3:0]       r_cc,   n_cc;
    logic [15:0]      r_prof, n_prof;
    logic [17:0]      r_blk,  n_blk;
    logic [7:0]       r_rem,  n_rem;
    logic [7:0]       r_pend, n_pend;

    logic [POS_W-1:0] rr;
    logic [POS_W:0]   vo;
    logic             hit;
    logic             in_block;
    logic             enter_ext;
    logic [7:0]       eid;
    logic [7:0]       elen;
    logic [7:0]       rem_dec;
    logic [7:0]       rem_inc;
    logic [17:0]      blk_dec;
    logic [17:0]      blk_new;
    logic [18:0]      off;
    logic [7:0]       pad;
    logic [SW-1:0]    rtp;
    logic [SW-1:0]    need;
    logic             err;

    assign rr      = r_pos - POS_W'(r_prefix);
    assign vo      = {1'b0, rr} + (POS_W+1)'(1);
    assign rem_dec = (r_rem != 8'd0) ? r_rem - 8'd1 : 8'd0;
    assign rem_inc = r_rem + 8'd1;
    assign blk_dec = (r_blk != 18'd0) ? r_blk - 18'd1 : 18'd0;

    always_comb begin
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_hdr0    = r_hdr0;
        n_hdr1    = r_hdr1;
        n_pad_f   = r_pad_f;
        n_ext_f   = r_ext_f;
        n_ovf     = r_ovf;
        n_cc      = r_cc;
        n_prof    = r_prof;
        n_blk     = r_blk;
        n_rem     = r_rem;
        n_pend    = r_pend;
        hit       = 1'b0;
        in_block  = 1'b0;
        enter_ext = 1'b0;
        eid       = 8'd0;
        elen      = 8'd0;
        blk_new   = 18'd0;

        if (r_pos >= POS_W'(MAX_PACKET_BYTES)) begin
            n_ovf = 1'b1;
        end else begin
            if (r_pos >= POS_W'(r_prefix)) begin
                unique case (r_phase)
                    rhep_pkg::PH_FIXED: begin
                        if (rr < POS_W'(8)) begin
                            n_hdr0 = r_hdr0 | (64'(i_byte) << {3'd7 - rr[2:0], 3'b000});
                        end else if (rr < POS_W'(12)) begin
                            n_hdr1 = r_hdr1 | (48'(i_byte) << {2'd3 - rr[1:0], 3'b000});
                        end
                        if (rr == '0) begin
                            n_pad_f = i_byte[5];
                            n_ext_f = i_byte[4];
                            n_cc    = i_byte[3:0];
                        end
                        if (rr >= POS_W'(11)) begin
                            if (r_cc != 4'd0) begin
                                n_phase = rhep_pkg::PH_CSRC;
                                n_rem   = {2'b00, r_cc, 2'b00};
                            end else begin
                                enter_ext = 1'b1;
                            end
                        end
                    end
                    rhep_pkg::PH_CSRC: begin
                        n_rem = rem_dec;
                        if (rem_dec == 8'd0) begin
                            enter_ext = 1'b1;
                        end
                    end
                    rhep_pkg::PH_EXTHDR: begin
                        case (r_rem)
                            8'd0:    n_prof = {i_byte, 8'h00};
                            8'd1:    n_prof = r_prof | 16'(i_byte);
                            8'd2:    n_hdr1 = r_hdr1 | (48'(i_byte) << 40);
                            default: n_hdr1 = r_hdr1 | (48'(i_byte) << 32);
                        endcase
                        n_rem = rem_inc;
                        if (rem_inc >= 8'd4) begin
                            n_rem   = 8'd0;
                            blk_new = {n_hdr1[47:32], 2'b00};
                            n_blk   = blk_new;
                            if (blk_new == 18'd0) begin
                                n_phase = rhep_pkg::PH_PAYLOAD;
                            end else if (n_prof == rhep_pkg::PROFILE_ONE_BYTE ||
                                         n_prof == rhep_pkg::PROFILE_TWO_BYTE) begin
                                n_phase = rhep_pkg::PH_WALK;
                            end else begin
                                n_phase = rhep_pkg::PH_SKIP;
                            end
                        end
                    end
                    rhep_pkg::PH_WALK: begin
                        in_block = 1'b1;
                        if (i_byte != 8'd0) begin
                            if (r_prof == rhep_pkg::PROFILE_ONE_BYTE) begin
                                eid     = {4'd0, i_byte[7:4]};
                                elen    = {4'd0, i_byte[3:0] & rhep_pkg::LOW_NIBBLE_MASK}
                                          + 8'd1;
                                hit     = 1'b1;
                                n_rem   = elen;
                                n_phase = rhep_pkg::PH_VALUE;
                            end else begin
                                n_pend  = i_byte;
                                n_phase = rhep_pkg::PH_LEN2;
                            end
                        end
                    end
                    rhep_pkg::PH_LEN2: begin
                        in_block = 1'b1;
                        eid      = r_pend;
                        elen     = i_byte;
                        hit      = 1'b1;
                        n_rem    = i_byte;
                        n_phase  = (i_byte != 8'd0) ? rhep_pkg::PH_VALUE : rhep_pkg::PH_WALK;
                    end
                    rhep_pkg::PH_VALUE: begin
                        in_block = 1'b1;
                        n_rem    = rem_dec;
                        if (rem_dec == 8'd0) begin
                            n_phase = rhep_pkg::PH_WALK;
                        end
                    end
                    rhep_pkg::PH_SKIP: begin
                        in_block = 1'b1;
                    end
                    default: begin
                    end
                endcase

                if (enter_ext) begin
                    if (r_ext_f) begin
                        n_phase = rhep_pkg::PH_EXTHDR;
                        n_rem   = 8'd0;
                    end else begin
                        n_phase = rhep_pkg::PH_PAYLOAD;
                    end
                end

                if (in_block) begin
                    n_blk = blk_dec;
                    if (blk_dec == 18'd0) begin
                        n_phase = rhep_pkg::PH_PAYLOAD;
                    end
                end
            end
            n_pos = r_pos + POS_W'(1);
        end

        off = 19'({n_cc, 2'b00});
        if (n_ext_f) begin
            off = off + 19'd4 + 19'({n_hdr1[47:32], 2'b00});
        end
        pad  = n_pad_f ? i_byte : 8'd0;
        rtp  = SW'(n_pos) - SW'(r_prefix);
        need = SW'(rhep_pkg::FIXED_HDR_BYTES) + SW'(off) + SW'(pad);
        err  = n_ovf;
        if (n_pos < POS_W'(r_prefix)) begin
            err = 1'b1;
        end else if (rtp < need) begin
            err = 1'b1;
        end

        o_res     = '0;
        o_has_res = 1'b0;
        if (i_last) begin
            o_has_res            = 1'b1;
            o_res.kind           = rhep_pkg::KIND_SUMMARY;
            o_res.seq_number     = n_hdr0[47:32];
            o_res.timestamp      = n_hdr0[31:0];
            o_res.ssrc           = n_hdr1[31:0];
            o_res.payload_type   = n_hdr0[54:48];
            o_res.marker         = n_hdr0[55];
            o_res.payload_offset = (off[18:16] != 3'd0) ? 16'hFFFF : off[15:0];
            o_res.payload_size   = err ? 16'd0 : 16'(rtp - need);
            o_res.error          = err;

            n_pos   = '0;
            n_phase = rhep_pkg::PH_FIXED;
            n_hdr0  = '0;
            n_hdr1  = '0;
            n_pad_f = 1'b0;
            n_ext_f = 1'b0;
            n_ovf   = 1'b0;
            n_cc    = '0;
            n_prof  = '0;
            n_blk   = '0;
            n_rem   = '0;
            n_pend  = '0;
        end else if (hit) begin
            o_has_res        = 1'b1;
            o_res.kind       = rhep_pkg::KIND_ELEMENT;
            o_res.ext_id     = eid;
            o_res.ext_length = elen;
            o_res.ext_offset = ((vo >> 16) != '0) ? 16'hFFFF : 16'(vo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
            r_pos    <= '0;
            r_phase  <= rhep_pkg::PH_FIXED;
            r_hdr0   <= '0;
            r_hdr1   <= '0;
            r_pad_f  <= 1'b0;
            r_ext_f  <= 1'b0;
            r_ovf    <= 1'b0;
            r_cc     <= '0;
            r_prof   <= '0;
            r_blk    <= '0;
            r_rem    <= '0;
            r_pend   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_prefix <= i_cfg_data;
            end
            if (i_fire) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_hdr0  <= n_hdr0;
                r_hdr1  <= n_hdr1;
                r_pad_f <= n_pad_f;
                r_ext_f <= n_ext_f;
                r_ovf   <= n_ovf;
                r_cc    <= n_cc;
                r_prof  <= n_prof;
                r_blk   <= n_blk;
                r_rem   <= n_rem;
                r_pend  <= n_pend;
            end
        end
    end

    `RHEP_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, i_fire && i_last, r_pos == '0 && r_phase == rhep_pkg::PH_FIXED && !r_ovf, "packet state not cleared after last byte")
    `RHEP_ASSERT_NOW(a_pos_bound, i_clk, i_rst_n, 1'b1, r_pos <= POS_W'(MAX_PACKET_BYTES), "byte position beyond packet limit")
    `RHEP_ASSERT_NOW(a_block_walk, i_clk, i_rst_n, r_phase == rhep_pkg::PH_WALK || r_phase == rhep_pkg::PH_SKIP, r_blk != 18'd0, "extension walk with empty block count")

endmodule

FILE: hw/rtl/rhep_out_stage.sv
// ----------------------------------------------------------------------------
// rhep_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module rhep_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_load,
    input  rhep_pkg::t_result i_res,
    output logic              o_valid,
    output rhep_pkg::t_result o_res
);

    logic              r_vld;
    rhep_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_advance) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RTP header extension parser. A queue-fed driver
// streams packets byte by byte (directed corner packets, well-formed RTP with
// one-byte, two-byte and unknown extension profiles, truncated packets, raw
// noise and one oversized packet) under several framing prefixes. A monitor
// runs a bit-accurate parser of its own on every accepted byte and compares
// each element and summary item field by field, with random gaps and stalls
// on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import rhep_pkg::*;

    // short packet limit keeps the oversized packet small
    localparam int PKT_LIMIT = 128;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        int unsigned gap;
    } wire_byte_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_data = 3'd0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_kind;
    logic [7:0]  o_ext_id;
    logic [7:0]  o_ext_length;
    logic [15:0] o_ext_offset;
    logic [15:0] o_seq_number;
    logic [31:0] o_timestamp;
    logic [31:0] o_ssrc;
    logic [6:0]  o_payload_type;
    logic        o_marker;
    logic [15:0] o_payload_offset;
    logic [15:0] o_payload_size;
    logic        o_error;

    rtp_header_extension_parser_top #(
        .MAX_PACKET_BYTES (PKT_LIMIT)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_ext_id         (o_ext_id),
        .o_ext_length     (o_ext_length),
        .o_ext_offset     (o_ext_offset),
        .o_seq_number     (o_seq_number),
        .o_timestamp      (o_timestamp),
        .o_ssrc           (o_ssrc),
        .o_payload_type   (o_payload_type),
        .o_marker         (o_marker),
        .o_payload_offset (o_payload_offset),
        .o_payload_size   (o_payload_size),
        .o_error          (o_error)
    );

    always #5 i_clk = ~i_clk;

    wire_byte_t  wire_bytes[$];
    logic [7:0]  pkt_bytes[$];
    t_result     parsed_results[$];

    int unsigned mismatches = 0;
    int unsigned n_summaries = 0;
    int unsigned n_elements = 0;
    int unsigned n_err_summaries = 0;
    int unsigned held_cycles = 0;
    int unsigned cur_prefix = 0;
    bit          rx_quiet = 1'b0;
    bit          rx_hold_req = 1'b0;

    // parser state
    logic [2:0]  cfg_prefix;
    int unsigned pos_cnt;
    t_phase      phase;
    logic [63:0] hdr_lo;
    logic [63:0] hdr_hi;
    bit          pad_f;
    bit          ext_f;
    bit          ovf_f;
    logic [3:0]  cc;
    logic [15:0] profile;
    int unsigned blk_left;
    int unsigned cnt;
    logic [7:0]  held_id;

    function automatic void restart_packet();
        pos_cnt = 0;
        phase = PH_FIXED;
        hdr_lo = '0;
        hdr_hi = '0;
        pad_f = 1'b0;
        ext_f = 1'b0;
        ovf_f = 1'b0;
        cc = '0;
        profile = '0;
        blk_left = 0;
        cnt = 0;
        held_id = '0;
    endfunction

    function automatic void leave_csrc();
        if (ext_f) begin
            phase = PH_EXTHDR;
            cnt = 0;
        end else begin
            phase = PH_PAYLOAD;
        end
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output t_result res);
        int unsigned r, total, off, pad, rtp, need, size, vo;
        bit          hit, err;
        logic [7:0]  eid, elen;
        res = '0;
        hit = 1'b0;
        r = 0;
        eid = '0;
        elen = '0;
        if (pos_cnt >= PKT_LIMIT) begin
            ovf_f = 1'b1;
        end else begin
            if (pos_cnt >= cfg_prefix) begin
                r = pos_cnt - cfg_prefix;
                case (phase)
                    PH_FIXED: begin
                        if (r < 8)
                            hdr_lo = hdr_lo | (64'(b) << (56 - 8 * r));
                        else if (r < 12)
                            hdr_hi = hdr_hi | (64'(b) << (24 - 8 * (r - 8)));
                        if (r == 0) begin
                            pad_f = b[5];
                            ext_f = b[4];
                            cc = b[3:0];
                        end
                        if (r >= 11) begin
                            if (cc != 0) begin
                                phase = PH_CSRC;
                                cnt = 32'(cc) << 2;
                            end else begin
                                leave_csrc();
                            end
                        end
                    end
                    PH_CSRC: begin
                        if (cnt > 0) cnt--;
                        if (cnt == 0) leave_csrc();
                    end
                    PH_EXTHDR: begin
                        if (cnt == 0)
                            profile = {b, 8'h00};
                        else if (cnt == 1)
                            profile = profile | 16'(b);
                        else if (cnt == 2)
                            hdr_hi = hdr_hi | (64'(b) << 40);
                        else
                            hdr_hi = hdr_hi | (64'(b) << 32);
                        cnt++;
                        if (cnt >= 4) begin
                            cnt = 0;
                            blk_left = 32'(hdr_hi[47:32]) << 2;
                            if (blk_left == 0)
                                phase = PH_PAYLOAD;
                            else if (profile == PROFILE_ONE_BYTE || profile == PROFILE_TWO_BYTE)
                                phase = PH_WALK;
                            else
                                phase = PH_SKIP;
                        end
                    end
                    PH_WALK, PH_LEN2, PH_VALUE, PH_SKIP: begin
                        if (phase == PH_WALK) begin
                            if (b != 0) begin
                                if (profile == PROFILE_ONE_BYTE) begin
                                    eid = {4'h0, b[7:4]};
                                    elen = 8'(b[3:0] & LOW_NIBBLE_MASK) + 8'd1;
                                    hit = 1'b1;
                                    cnt = elen;
                                    phase = PH_VALUE;
                                end else begin
                                    held_id = b;
                                    phase = PH_LEN2;
                                end
                            end
                        end else if (phase == PH_LEN2) begin
                            eid = held_id;
                            elen = b;
                            hit = 1'b1;
                            cnt = b;
                            phase = (b != 0) ? PH_VALUE : PH_WALK;
                        end else if (phase == PH_VALUE) begin
                            if (cnt > 0) cnt--;
                            if (cnt == 0) phase = PH_WALK;
                        end
                        if (blk_left > 0) blk_left--;
                        if (blk_left == 0) phase = PH_PAYLOAD;
                    end
                    default: begin
                    end
                endcase
            end
            pos_cnt++;
        end

        if (last) begin
            total = pos_cnt;
            off = 32'(cc) << 2;
            pad = pad_f ? 32'(b) : 0;
            err = ovf_f;
            size = 0;
            if (ext_f)
                off = off + 4 + (32'(hdr_hi[47:32]) << 2);
            if (total < cfg_prefix) begin
                err = 1'b1;
            end else begin
                rtp = total - cfg_prefix;
                need = 32'(FIXED_HDR_BYTES) + off + pad;
                if (rtp < need)
                    err = 1'b1;
                else
                    size = rtp - need;
            end
            if (err) size = 0;
            res.kind = KIND_SUMMARY;
            res.seq_number = hdr_lo[47:32];
            res.timestamp = hdr_lo[31:0];
            res.ssrc = hdr_hi[31:0];
            res.payload_type = hdr_lo[54:48];
            res.marker = hdr_lo[55];
            res.payload_offset = (off > 32'hFFFF) ? 16'hFFFF : off[15:0];
            res.payload_size = size[15:0];
            res.error = err;
            restart_packet();
            return 1'b1;
        end
        if (hit) begin
            vo = r + 1;
            res.kind = KIND_ELEMENT;
            res.ext_id = eid;
            res.ext_length = elen;
            res.ext_offset = (vo > 32'hFFFF) ? 16'hFFFF : vo[15:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
        end
    endfunction

    function automatic int unsigned idle_len();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 85) return $urandom_range(1, 3);
        if (sel < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // driver
    int unsigned tx_idle = 0;
    always @(posedge i_clk) begin : drv
        wire_byte_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data_byte <= 8'd0;
            i_last_byte <= 1'b0;
            tx_idle = 0;
        end else if (!i_valid || !o_stall) begin
            if (tx_idle > 0) begin
                tx_idle--;
                i_valid <= 1'b0;
            end else if (wire_bytes.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                nxt = wire_bytes.pop_front();
                i_valid <= 1'b1;
                i_data_byte <= nxt.data;
                i_last_byte <= nxt.last;
                tx_idle = nxt.gap;
            end
        end
    end

    // receiver back-pressure
    int unsigned hold_cnt = 0;
    int unsigned stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_cnt = 0;
            stall_left = 0;
        end else begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len();
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_result got, want, pred;
        if (!i_rst_n) begin
            cfg_prefix = 3'd0;
            restart_packet();
        end else begin
            if (i_cfg_we) cfg_prefix = i_cfg_data;
            if (i_valid && o_stall) held_cycles++;
            if (o_valid && !i_stall) begin
                got = {o_kind, o_ext_id, o_ext_length, o_ext_offset, o_seq_number,
                       o_timestamp, o_ssrc, o_payload_type, o_marker,
                       o_payload_offset, o_payload_size, o_error};
                if (got.kind == KIND_SUMMARY) begin
                    n_summaries++;
                    if (got.error) n_err_summaries++;
                end else begin
                    n_elements++;
                end
                if (parsed_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result item mismatch, expected none, got kind %0d id 0x%0h",
                             $time, got.kind, got.ext_id);
                end else begin
                    want = parsed_results.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("ext_id", want.ext_id, got.ext_id);
                    check_field("ext_length", want.ext_length, got.ext_length);
                    check_field("ext_offset", want.ext_offset, got.ext_offset);
                    check_field("seq_number", want.seq_number, got.seq_number);
                    check_field("timestamp", want.timestamp, got.timestamp);
                    check_field("ssrc", want.ssrc, got.ssrc);
                    check_field("payload_type", want.payload_type, got.payload_type);
                    check_field("marker", want.marker, got.marker);
                    check_field("payload_offset", want.payload_offset, got.payload_offset);
                    check_field("payload_size", want.payload_size, got.payload_size);
                    check_field("error", want.error, got.error);
                end
            end
            if (i_valid && !o_stall) begin
                if (parse_byte(i_data_byte, i_last_byte, pred))
                    parsed_results.push_back(pred);
            end
        end
    end

    task automatic queue_packet(input bit steady);
        wire_byte_t wb;
        foreach (pkt_bytes[i]) begin
            wb.data = pkt_bytes[i];
            wb.last = (i == pkt_bytes.size() - 1);
            wb.gap = steady ? 0 : idle_len();
            wire_bytes.push_back(wb);
        end
    endtask

    task automatic build_rtp(input int unsigned pre);
        int unsigned ncsrc, words, blk, k, len, plen, sel;
        logic [15:0] prof;
        bit          pad, ext;
        pkt_bytes.delete();
        repeat (pre) pkt_bytes.push_back(8'($urandom));
        pad = ($urandom_range(0, 3) == 0);
        ext = ($urandom_range(0, 3) != 0);
        ncsrc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
        pkt_bytes.push_back({2'($urandom), pad, ext, 4'(ncsrc)});
        repeat (11 + 4 * ncsrc) pkt_bytes.push_back(8'($urandom));
        if (ext) begin
            sel = $urandom_range(0, 9);
            prof = (sel < 4) ? PROFILE_ONE_BYTE : (sel < 8) ? PROFILE_TWO_BYTE : 16'($urandom);
            words = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
            pkt_bytes.push_back(prof[15:8]);
            pkt_bytes.push_back(prof[7:0]);
            pkt_bytes.push_back(8'(words >> 8));
            pkt_bytes.push_back(8'(words));
            blk = 4 * words;
            k = 0;
            while (k < blk) begin
                if ($urandom_range(0, 4) == 0) begin
                    len = 0;
                    pkt_bytes.push_back(8'h00);
                end else if (prof == PROFILE_ONE_BYTE) begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                       : $urandom_range(1, 3);
                    pkt_bytes.push_back({4'($urandom), 4'(len - 1)});
                end else begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(0, 3);
                    pkt_bytes.push_back(8'($urandom_range(1, 255)));
                    pkt_bytes.push_back(8'(len));
                    k++;
                end
                k++;
                repeat (len) begin
                    if (k < blk) begin
                        pkt_bytes.push_back(8'($urandom));
                        k++;
                    end
                end
            end
        end
        plen = $urandom_range(0, 12);
        repeat (plen) pkt_bytes.push_back(8'($urandom));
        if (pad && plen != 0)
            pkt_bytes[pkt_bytes.size() - 1] = ($urandom_range(0, 4) == 0)
                ? 8'($urandom) : 8'($urandom_range(1, plen));
    endtask

    task automatic random_traffic(input int unsigned target, input bit steady);
        int unsigned sent, sel;
        sent = 0;
        while (sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 85) begin
                build_rtp(cur_prefix);
                if (sel >= 70)
                    repeat ($urandom_range(0, pkt_bytes.size() - 1))
                        void'(pkt_bytes.pop_back());
            end else begin
                pkt_bytes.delete();
                repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom));
            end
            sent += pkt_bytes.size();
            queue_packet(steady);
        end
    endtask

    task automatic drain();
        while (wire_bytes.size() != 0 || i_valid || parsed_results.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_prefix(input int unsigned value);
        cur_prefix = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= 3'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int unsigned mark;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_prefix(0);
        // too short, every flag set
        pkt_bytes = '{8'hFF};
        queue_packet(1'b0);
        // two-byte profile, id byte cut by the block end
        pkt_bytes = '{8'h90, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h10, 8'h00, 8'h00, 8'h01,
                      8'h05, 8'h01, 8'hAA, 8'h07, 8'h00};
        queue_packet(1'b0);
        // one-byte profile, id 15 header on the final byte
        pkt_bytes = '{8'h90, 8'h00, 8'h12, 8'h34, 8'h01, 8'h02, 8'h03, 8'h04,
                      8'h05, 8'h06, 8'h07, 8'h08, 8'hBE, 8'hDE, 8'h00, 8'h01,
                      8'h00, 8'hF0};
        queue_packet(1'b0);
        random_traffic(100, 1'b0);
        drain();

        write_prefix(4);
        rx_quiet = 1'b1;
        random_traffic(120, 1'b1);
        mark = wire_bytes.size();
        while (wire_bytes.size() + 20 > mark) @(posedge i_clk);
        rx_hold_req = 1'b1;
        drain();
        rx_quiet = 1'b0;

        write_prefix(7);
        random_traffic(120, 1'b0);
        drain();

        // oversized packet: element header at the last counted offset
        write_prefix(0);
        pkt_bytes = '{8'h90, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h12, 8'h34, 8'h56, 8'h78, 8'hBE, 8'hDE, 8'hFF, 8'hFF};
        while (pkt_bytes.size() < PKT_LIMIT - 1) pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h10);
        pkt_bytes.push_back(8'hA5);
        pkt_bytes.push_back(8'h5A);
        queue_packet(1'b1);
        drain();

        write_prefix(3);
        random_traffic(120, 1'b0);
        drain();

        $display("run: %0d packets closed (%0d with error), %0d extension elements",
                 n_summaries, n_err_summaries, n_elements);
        $display("run: prefixes 0/4/7/0/3, oversized packet included, input held %0d cycles",
                 held_cycles);
        if (mismatches == 0 && parsed_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rhep_pkg.sv
hw/rtl/rhep_in_stage.sv
hw/rtl/rhep_parser.sv
hw/rtl/rhep_out_stage.sv
hw/rtl/rtp_header_extension_parser_top.sv
bench/tb_top.sv
